// ===== sv/rsi_pkg.sv =====
// Shared types, sizes and helpers for the ray/sphere intersection pipeline.
// Used by every module of the block; depends on nothing else.
package rsi_pkg;

  // config port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // square root chain: one result bit per cell
  localparam int SQRT_N     = 52;
  localparam int SQRT_RAD_W = 2 * SQRT_N;
  localparam int SQRT_REM_W = SQRT_N + 2;

  // normal division chain: one quotient bit per cell
  localparam int DIV_N = 15;
  localparam int DIV_W = 64;
  localparam logic [DIV_N-1:0] NORM_ONE = DIV_N'(16384);

  // registered stages outside the two chains: 5 + 4 + 1 + 1
  localparam int PIPE_STAGES = 11 + 2 * SQRT_N + DIV_N;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_RADIUS
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit_flag;
    logic signed [31:0] hit_distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } hit_t;

  typedef struct packed {
    logic [SQRT_RAD_W-1:0] rad;
    logic [SQRT_REM_W-1:0] rem;
    logic [SQRT_N-1:0]     root;
  } sqrt_step_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dv;
    logic [DIV_N-1:0] q;
  } div_step_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/rsi_cfg.sv =====
// Sphere register file behind the APB-style port.
// Depends on rsi_pkg for the register map and the config struct.
module rsi_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rsi_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output rsi_pkg::cfg_t                  cfg
);
  import rsi_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_CENTER_X: cfg.center_x <= pwdata;
        REG_CENTER_Y: cfg.center_y <= pwdata;
        REG_CENTER_Z: cfg.center_z <= pwdata;
        REG_RADIUS:   cfg.radius   <= pwdata[30:0];
        default:      cfg          <= cfg;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CENTER_X: prdata = cfg.center_x;
      REG_CENTER_Y: prdata = cfg.center_y;
      REG_CENTER_Z: prdata = cfg.center_z;
      REG_RADIUS:   prdata = {1'b0, cfg.radius};
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== sv/rsi_sqrt_cell.sv =====
// One registered digit step of the restoring square root.
// Depends on rsi_pkg for the step struct.
module rsi_sqrt_cell (
  input  logic                clk,
  input  rsi_pkg::sqrt_step_t step_in,
  output rsi_pkg::sqrt_step_t step_out
);
  import rsi_pkg::*;

  logic [SQRT_REM_W+1:0] rem4;
  logic [SQRT_REM_W+1:0] trial;
  logic [SQRT_REM_W+1:0] diff;
  logic                  fits;

  always_comb begin
    rem4  = {step_in.rem, step_in.rad[SQRT_RAD_W-1 -: 2]};
    trial = {2'b00, step_in.root, 2'b01};
    diff  = rem4 - trial;
    fits  = rem4 >= trial;
  end

  always_ff @(posedge clk) begin
    step_out.rad <= {step_in.rad[SQRT_RAD_W-3:0], 2'b00};
    if (fits) begin
      step_out.rem  <= diff[SQRT_REM_W-1:0];
      step_out.root <= {step_in.root[SQRT_N-2:0], 1'b1};
    end else begin
      step_out.rem  <= rem4[SQRT_REM_W-1:0];
      step_out.root <= {step_in.root[SQRT_N-2:0], 1'b0};
    end
  end

endmodule

// ===== sv/rsi_sqrt_chain.sv =====
// Row of square root cells: floor square root, one result bit per cycle of depth.
// Depends on rsi_pkg and rsi_sqrt_cell.
module rsi_sqrt_chain (
  input  logic                           clk,
  input  logic [rsi_pkg::SQRT_RAD_W-1:0] rad,
  output logic [rsi_pkg::SQRT_N-1:0]     root
);
  import rsi_pkg::*;

  sqrt_step_t head;
  sqrt_step_t stage [SQRT_N];

  always_comb begin
    head.rad  = rad;
    head.rem  = '0;
    head.root = '0;
  end

  for (genvar i = 0; i < SQRT_N; i++) begin : g_cell
    if (i == 0) begin : g_first
      rsi_sqrt_cell u_cell (.clk(clk), .step_in(head), .step_out(stage[i]));
    end else begin : g_next
      rsi_sqrt_cell u_cell (.clk(clk), .step_in(stage[i-1]), .step_out(stage[i]));
    end
  end

  assign root = stage[SQRT_N-1].root;

endmodule

// ===== sv/rsi_div_cell.sv =====
// One registered quotient bit of the restoring divider used for the normal.
// Depends on rsi_pkg for the step struct.
module rsi_div_cell (
  input  logic               clk,
  input  rsi_pkg::div_step_t step_in,
  output rsi_pkg::div_step_t step_out
);
  import rsi_pkg::*;

  logic             fits;
  logic [DIV_W-1:0] diff;

  always_comb begin
    fits = step_in.rem >= step_in.dv;
    diff = step_in.rem - step_in.dv;
  end

  always_ff @(posedge clk) begin
    step_out.rem <= fits ? diff : step_in.rem;
    step_out.dv  <= step_in.dv >> 1;
    step_out.q   <= {step_in.q[DIV_N-2:0], fits};
  end

endmodule

// ===== sv/ray_sphere_intersect.sv =====
// Ray/sphere intersection pipeline, top level.
// Depends on rsi_pkg, rsi_cfg, rsi_sqrt_chain (rsi_sqrt_cell) and rsi_div_cell.
//
// Usage:
//   The sphere (center, radius) sits in four registers on the APB-style port
//   at byte addresses 0, 4, 8 and 12; write them while no ray is in flight.
//   A ray transfers on any edge where start is high and busy is low. busy
//   never rises, so one ray can be taken every cycle.
//   Each ray gives one result: done is high for exactly one cycle, with the
//   result struct valid in that cycle.
//   Results leave in the order the rays came in. The receiver cannot stall:
//   a result not taken in its done cycle is gone.
//   Latency is set by two 52-cell square root rows (discriminant, then the
//   normal length), the 15-cell divider row for the normal components and
//   eleven further register stages for products, sums and rounding.
//   On a miss every result field is zero.
//   Reset clears the sphere registers to zero and drops all rays in flight.
module ray_sphere_intersect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rsi_pkg::ray_t                  ray,
  output logic                           done,
  output rsi_pkg::hit_t                  result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsi_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rsi_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rsi_pkg::*;

  typedef struct packed {
    logic signed [49:0] h;
    logic               dneg;
    logic               dzero;
    ray_t               ray;
  } side1_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] tq;
    logic [2:0][31:0]   p;
    logic [2:0][31:0]   nmag;
    logic [2:0]         nneg;
  } side2_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] tq;
    logic [2:0][31:0]   p;
    logic [2:0]         nneg;
    logic [2:0]         ovf;
    logic               lenzero;
  } side3_t;

  function automatic logic signed [31:0] org_of(input ray_t r, input int k);
    logic signed [31:0] v;
    case (k)
      0:       v = r.origin_x;
      1:       v = r.origin_y;
      default: v = r.origin_z;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] dir_of(input ray_t r, input int k);
    logic signed [15:0] v;
    case (k)
      0:       v = r.dir_x;
      1:       v = r.dir_y;
      default: v = r.dir_z;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] ctr_of(input cfg_t c, input int k);
    logic signed [31:0] v;
    case (k)
      0:       v = c.center_x;
      1:       v = c.center_y;
      default: v = c.center_z;
    endcase
    return v;
  endfunction

  cfg_t cfg;
  logic accept;
  logic [PIPE_STAGES-1:0] vpipe;

  rsi_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign done   = vpipe[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE_STAGES-2:0], accept};
    end
  end

  // ---- offset from centre ----
  ray_t               ray1;
  logic signed [32:0] lv1 [3];

  always_ff @(posedge clk) begin
    ray1 <= ray;
    for (int i = 0; i < 3; i++) begin
      lv1[i] <= 33'(org_of(ray, i)) - 33'(ctr_of(cfg, i));
    end
  end

  // ---- products ----
  logic [31:0]        lmag [3];
  ray_t               ray2;
  logic signed [48:0] p2 [3];
  logic [63:0]        q2 [3];
  logic [61:0]        r2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lmag[i] = lv1[i][32] ? 32'(-lv1[i]) : lv1[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    ray2 <= ray1;
    r2   <= cfg.radius * cfg.radius;
    for (int i = 0; i < 3; i++) begin
      p2[i] <= dir_of(ray1, i) * lv1[i];
      q2[i] <= lmag[i] * lmag[i];
    end
  end

  // ---- h = d.L, c = L.L - r^2 ----
  logic [65:0]        ll_sum;
  ray_t               ray3;
  logic signed [49:0] h3;
  logic signed [66:0] cq3;

  assign ll_sum = 66'(q2[0]) + 66'(q2[1]) + 66'(q2[2]);

  always_ff @(posedge clk) begin
    ray3 <= ray2;
    h3   <= 50'(p2[0]) + 50'(p2[1]) + 50'(p2[2]);
    cq3  <= $signed({1'b0, ll_sum}) - $signed({5'd0, r2});
  end

  // ---- h^2 as three partial products ----
  logic [48:0]        hmag;
  ray_t               ray4;
  logic signed [49:0] h4;
  logic signed [66:0] cq4;
  logic [49:0]        hh4;
  logic [48:0]        hl4;
  logic [47:0]        lo4;

  assign hmag = h3[49] ? 49'(-h3) : h3[48:0];

  always_ff @(posedge clk) begin
    ray4 <= ray3;
    h4   <= h3;
    cq4  <= cq3;
    hh4  <= hmag[48:24] * hmag[48:24];
    hl4  <= hmag[48:24] * hmag[23:0];
    lo4  <= hmag[23:0] * hmag[23:0];
  end

  // ---- discriminant / 4 ----
  logic [97:0]        hsq;
  ray_t               ray5;
  logic signed [49:0] h5;
  logic signed [98:0] dsc5;

  assign hsq = {hh4, 48'd0} + 98'({hl4, 25'd0}) + 98'(lo4);

  always_ff @(posedge clk) begin
    ray5 <= ray4;
    h5   <= h4;
    dsc5 <= $signed({1'b0, hsq}) - $signed({cq4, 28'd0});
  end

  // ---- first square root row ----
  logic [SQRT_N-1:0] root1;
  side1_t            side1 [SQRT_N];

  rsi_sqrt_chain u_sqrt_dsc (
    .clk(clk), .rad({(SQRT_RAD_W - 99)'(0), dsc5}), .root(root1)
  );

  always_ff @(posedge clk) begin
    side1[0] <= '{h: h5, dneg: dsc5[98], dzero: (dsc5 == '0), ray: ray5};
    for (int i = 1; i < SQRT_N; i++) begin
      side1[i] <= side1[i-1];
    end
  end

  // ---- root choice and t rounding ----
  side1_t             s1;
  logic signed [53:0] s_ext, nh, t1, t2, tsel, tr;
  logic               hit_c;
  logic               hit6;
  logic signed [31:0] tq6;
  ray_t               ray6;

  always_comb begin
    s1    = side1[SQRT_N-1];
    s_ext = $signed({2'b00, root1});
    nh    = -54'(s1.h);
    t1    = nh - s_ext;
    t2    = nh + s_ext;
    // tangent ray takes -h unchecked; else nearest root that is not behind
    if (s1.dzero) begin
      tsel = nh;
    end else begin
      tsel = t1[53] ? t2 : t1;
    end
    hit_c = ~s1.dneg & (s1.dzero | ~t2[53]);
    tr    = (tsel + 54'sd8192) >>> 14;
  end

  always_ff @(posedge clk) begin
    hit6 <= hit_c;
    tq6  <= sat32(64'(tr));
    ray6 <= s1.ray;
  end

  // ---- t * d ----
  logic               hit7;
  logic signed [31:0] tq7;
  ray_t               ray7;
  logic signed [47:0] m7 [3];

  always_ff @(posedge clk) begin
    hit7 <= hit6;
    tq7  <= tq6;
    ray7 <= ray6;
    for (int i = 0; i < 3; i++) begin
      m7[i] <= tq6 * dir_of(ray6, i);
    end
  end

  // ---- hit point and offset from centre ----
  logic signed [47:0] rr [3];
  logic signed [31:0] pc [3];
  logic signed [32:0] nc [3];
  logic               hit8;
  logic signed [31:0] tq8;
  logic [2:0][31:0]   p8, nmag8;
  logic [2:0]         nneg8;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = (m7[i] + 48'sd8192) >>> 14;
      pc[i] = sat32(64'(org_of(ray7, i)) + 64'(rr[i]));
      nc[i] = 33'(pc[i]) - 33'(ctr_of(cfg, i));
    end
  end

  always_ff @(posedge clk) begin
    hit8 <= hit7;
    tq8  <= tq7;
    for (int i = 0; i < 3; i++) begin
      p8[i]    <= pc[i];
      nneg8[i] <= nc[i][32];
      nmag8[i] <= nc[i][32] ? 32'(-nc[i]) : nc[i][31:0];
    end
  end

  // ---- squares of the normal ----
  logic               hit9;
  logic signed [31:0] tq9;
  logic [2:0][31:0]   p9, nmag9;
  logic [2:0]         nneg9;
  logic [63:0]        nsq9 [3];
  logic [65:0]        nsum;

  always_ff @(posedge clk) begin
    hit9  <= hit8;
    tq9   <= tq8;
    p9    <= p8;
    nmag9 <= nmag8;
    nneg9 <= nneg8;
    for (int i = 0; i < 3; i++) begin
      nsq9[i] <= nmag8[i] * nmag8[i];
    end
  end

  assign nsum = 66'(nsq9[0]) + 66'(nsq9[1]) + 66'(nsq9[2]);

  // ---- second square root row: normal length ----
  logic [SQRT_N-1:0] root2;
  side2_t            side2 [SQRT_N];

  rsi_sqrt_chain u_sqrt_len (
    .clk(clk), .rad({(SQRT_RAD_W - 94)'(0), nsum, 28'd0}), .root(root2)
  );

  always_ff @(posedge clk) begin
    side2[0] <= '{hit: hit9, tq: tq9, p: p9, nmag: nmag9, nneg: nneg9};
    for (int i = 1; i < SQRT_N; i++) begin
      side2[i] <= side2[i-1];
    end
  end

  // ---- divider set-up: rounded numerator, overflow past the quotient range ----
  side2_t           s2;
  logic [DIV_W-1:0] len64;
  logic [DIV_W-1:0] num [3];
  logic [2:0]       ovf_c;
  div_step_t        div_head [3];
  side3_t           side3 [DIV_N+1];

  always_comb begin
    s2    = side2[SQRT_N-1];
    len64 = DIV_W'(root2);
    for (int i = 0; i < 3; i++) begin
      num[i]   = {4'd0, s2.nmag[i], 28'd0} + (len64 >> 1);
      ovf_c[i] = num[i] >= (len64 << DIV_N);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      div_head[i] <= '{rem: num[i], dv: len64 << (DIV_N - 1), q: '0};
    end
    side3[0] <= '{hit: s2.hit, tq: s2.tq, p: s2.p, nneg: s2.nneg, ovf: ovf_c,
                  lenzero: (root2 == '0)};
    for (int i = 1; i <= DIV_N; i++) begin
      side3[i] <= side3[i-1];
    end
  end

  // ---- divider rows, one lane per axis ----
  div_step_t dstage [DIV_N][3];

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    for (genvar k = 0; k < 3; k++) begin : g_lane
      if (j == 0) begin : g_first
        rsi_div_cell u_cell (.clk(clk), .step_in(div_head[k]), .step_out(dstage[j][k]));
      end else begin : g_next
        rsi_div_cell u_cell (.clk(clk), .step_in(dstage[j-1][k]), .step_out(dstage[j][k]));
      end
    end
  end

  // ---- clamp, sign and output register ----
  side3_t             s3;
  logic [DIV_N-1:0]   qc [3];
  logic signed [15:0] nv [3];
  hit_t               result_next;

  always_comb begin
    s3 = side3[DIV_N];
    for (int i = 0; i < 3; i++) begin
      qc[i] = (s3.ovf[i] || dstage[DIV_N-1][i].q > NORM_ONE) ? NORM_ONE
                                                               : dstage[DIV_N-1][i].q;
      nv[i] = s3.nneg[i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
      if (s3.lenzero) begin
        nv[i] = '0;
      end
    end
    result_next.hit_flag     = 1'b1;
    result_next.hit_distance = s3.tq;
    result_next.point_x      = s3.p[0];
    result_next.point_y      = s3.p[1];
    result_next.point_z      = s3.p[2];
    result_next.normal_x     = nv[0];
    result_next.normal_y     = nv[1];
    result_next.normal_z     = nv[2];
    // drop everything on a miss
    if (!s3.hit) begin
      result_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_STAGES done)
    else $error("ray transfer produced no result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_STAGES))
    else $error("result strobe without a matching ray transfer");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit_flag |-> result.hit_distance == '0 && result.point_x == '0 &&
      result.normal_x == '0 && result.normal_z == '0)
    else $error("miss result carries non-zero fields");

  a_norm_clamp: assert property (@(posedge clk) disable iff (rst)
    done |-> result.normal_x <= 16'sd16384 && result.normal_x >= -16'sd16384 &&
      result.normal_y <= 16'sd16384 && result.normal_y >= -16'sd16384 &&
      result.normal_z <= 16'sd16384 && result.normal_z >= -16'sd16384)
    else $error("normal component beyond unit range");

endmodule

// ===== tb/sv/ray_sphere_intersect_test.sv =====
// Self-checking testbench for the ray/sphere intersection pipeline.
// Drives rays and sphere settings, predicts every hit record and compares.
// Depends on rsi_pkg and ray_sphere_intersect.
module ray_sphere_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int LATENCY  = 130;
  localparam int WDOG_MAX = 5000;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  ray_t                  ray;
  logic                  done;
  hit_t                  result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  cfg_t sphere;
  ray_t ray_queue[$];
  hit_t hit_queue[$];
  int   rays_queued;
  int   rays_taken;
  int   quiet_cycles;
  bit   no_gaps;
  bit   failed;

  ray_sphere_intersect uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .ray(ray),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_root(input logic [127:0] x);
    logic [63:0]  acc;
    logic [127:0] cand;
    acc = '0;
    for (int b = 62; b >= 0; b--) begin
      cand = acc | (64'd1 << b);
      if (cand * cand <= x) acc = cand[63:0];
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = x;
    if (x > 64'sd2147483647) r = 64'sd2147483647;
    if (x < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic logic signed [15:0] unit_comp(input logic signed [63:0] n,
                                                   input logic [63:0] len);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (n < 0) ? -n : n;
    mag = mag << 28;
    q = (mag + len / 2) / len;
    if (q > 128'd16384) q = 128'd16384;
    return (n < 0) ? -q[15:0] : q[15:0];
  endfunction

  function automatic hit_t predict_hit(input ray_t r, input cfg_t s);
    logic signed [63:0]  o[3], d[3], c[3], l[3], p[3], nv[3];
    logic signed [63:0]  h, t, tq, sq, t1, t2, rr;
    logic signed [127:0] ll, disc, nn;
    logic [63:0]         len;
    hit_t                res;
    res = '0;
    o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
    d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
    c[0] = s.center_x; c[1] = s.center_y; c[2] = s.center_z;
    rr = {33'd0, s.radius};
    h = 0;
    ll = 0;
    for (int i = 0; i < 3; i++) begin
      l[i] = o[i] - c[i];
      h += d[i] * l[i];
      ll += 128'(l[i]) * 128'(l[i]);
    end
    disc = 128'(h) * 128'(h) - ((ll - 128'(rr) * 128'(rr)) <<< 28);
    if (disc < 0) return res;
    if (disc == 0) begin
      t = -h;
    end else begin
      sq = floor_root(disc);
      t1 = -h - sq;
      t2 = -h + sq;
      if (t2 < 0) return res;
      t = (t1 >= 0) ? t1 : t2;
    end
    tq = clamp32((t + 64'sd8192) >>> 14);
    nn = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = clamp32(o[i] + ((tq * d[i] + 64'sd8192) >>> 14));
      nv[i] = p[i] - c[i];
      nn += 128'(nv[i]) * 128'(nv[i]);
    end
    res.hit_flag = 1'b1;
    res.hit_distance = tq[31:0];
    res.point_x = p[0][31:0];
    res.point_y = p[1][31:0];
    res.point_z = p[2][31:0];
    len = floor_root(nn <<< 28);
    if (len != 0) begin
      res.normal_x = unit_comp(nv[0], len);
      res.normal_y = unit_comp(nv[1], len);
      res.normal_z = unit_comp(nv[2], len);
    end
    return res;
  endfunction

  // driver: take a ray on every transfer, then offer the next or hold a gap
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        hit_queue.push_back(predict_hit(ray, sphere));
        rays_taken++;
      end
      if (!start || !busy) begin
        if (ray_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 19)) begin
          start <= 1'b1;
          ray <= ray_queue.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // monitor and watchdog
  always @(posedge clk) begin
    hit_t exp_hit;
    if (!rst) begin
      if (done) begin
        if (hit_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          failed = 1'b1;
        end else begin
          exp_hit = hit_queue.pop_front();
          check_field("hit_flag", 32'(exp_hit.hit_flag), 32'(result.hit_flag));
          check_field("hit_distance", exp_hit.hit_distance, result.hit_distance);
          check_field("point_x", exp_hit.point_x, result.point_x);
          check_field("point_y", exp_hit.point_y, result.point_y);
          check_field("point_z", exp_hit.point_z, result.point_z);
          check_field("normal_x", 32'(exp_hit.normal_x), 32'(result.normal_x));
          check_field("normal_y", 32'(exp_hit.normal_y), 32'(result.normal_y));
          check_field("normal_z", 32'(exp_hit.normal_z), 32'(result.normal_z));
        end
      end
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: sphere.center_x = value;
      REG_CENTER_Y: sphere.center_y = value;
      REG_CENTER_Z: sphere.center_z = value;
      REG_RADIUS:   sphere.radius = value[30:0];
      default:      ;
    endcase
  endtask

  task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                            input logic [31:0] cz, input logic [31:0] rad);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, rad);
  endtask

  task automatic queue_ray(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [15:0] dx,
                           input logic [15:0] dy, input logic [15:0] dz);
    ray_t item;
    item.origin_x = ox; item.origin_y = oy; item.origin_z = oz;
    item.dir_x = dx;    item.dir_y = dy;    item.dir_z = dz;
    ray_queue.push_back(item);
    rays_queued++;
  endtask

  function automatic logic [31:0] to_q32(input real v);
    real c;
    c = v;
    if (c > 2147483647.0) c = 2147483647.0;
    if (c < -2147483648.0) c = -2147483648.0;
    return 32'($rtoi(c));
  endfunction

  function automatic real jitter();
    return (real'($urandom_range(2000)) - 1000.0) / 1000.0;
  endfunction

  // mostly rays aimed near the sphere, the rest raw noise
  task automatic queue_random(input int count);
    real cen[3], org[3], dv[3], rad, span, mag, scale;
    logic [31:0] oq[3];
    logic [15:0] dq[3];
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) == 0) begin
        queue_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        cen[0] = real'(sphere.center_x);
        cen[1] = real'(sphere.center_y);
        cen[2] = real'(sphere.center_z);
        rad = real'(sphere.radius);
        span = 3.0 * rad + 65536.0;
        for (int i = 0; i < 3; i++) begin
          oq[i] = to_q32(cen[i] + jitter() * span);
          org[i] = real'($signed(oq[i]));
          dv[i] = cen[i] + 1.2 * jitter() * rad - org[i];
        end
        mag = $sqrt(dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2]);
        scale = ($urandom_range(7) == 0) ? 8192.0 + real'($urandom_range(16384)) : 16384.0;
        for (int i = 0; i < 3; i++)
          dq[i] = (mag > 0.0) ? 16'($rtoi(dv[i] / mag * scale)) : ((i == 0) ? 16'd16384 : '0);
        queue_ray(oq[0], oq[1], oq[2], dq[0], dq[1], dq[2]);
      end
    end
  endtask

  task automatic drain();
    wait (rays_taken == rays_queued && hit_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    ray = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sphere = '0;
    rays_queued = 0;
    rays_taken = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    failed = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // point sphere at the origin: zero normal, extremes of the fields
    set_sphere(32'd0, 32'd0, 32'd0, 32'd0);
    queue_ray(-32'sd131072, 32'd0, 32'd0, 16'sd16384, 16'd0, 16'd0);
    queue_ray(32'd0, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0);
    queue_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'sd16384, 16'sd16384, 16'sd16384);
    queue_ray(32'h80000000, 32'h80000000, 32'h80000000,
              -16'sd16384, -16'sd16384, -16'sd16384);
    queue_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h7fff, 16'h8000);
    queue_ray(32'h7fffffff, 32'h80000000, 32'hffffffff, 16'h7fff, 16'h8000, 16'hffff);
    drain();

    // unit sphere: tangent, inside, two roots, behind, clear miss
    set_sphere(32'd0, 32'd0, 32'd0, 32'd65536);
    queue_ray(-32'sd327680, 32'sd65536, 32'd0, 16'sd16384, 16'd0, 16'd0);
    queue_ray(32'd0, 32'd0, 32'd0, 16'd0, 16'sd16384, 16'd0);
    queue_ray(32'd0, 32'd0, -32'sd327680, 16'd0, 16'd0, 16'sd16384);
    queue_ray(32'd0, 32'd0, 32'sd327680, 16'd0, 16'd0, 16'sd16384);
    queue_ray(32'd0, 32'sd196608, 32'd0, 16'sd16384, 16'd0, 16'd0);
    queue_ray(32'd0, 32'd0, -32'sd327680, 16'd0, 16'd0, 16'h7fff);
    queue_random(60);
    drain();

    no_gaps = 1'b1;
    set_sphere($urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000,
               $urandom_range(2000000) - 1000000, 32'd655360);
    queue_random(150);
    drain();
    no_gaps = 1'b0;

    set_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    queue_random(90);
    drain();

    set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 32'd1);
    queue_random(90);
    drain();

    set_sphere($urandom, $urandom, $urandom, $urandom);
    queue_random(90);
    drain();

    set_sphere($urandom_range(20000000) - 10000000, $urandom, 32'd0, 32'd2621440);
    queue_random(120);
    drain();

    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rsi_pkg.sv
sv/rsi_cfg.sv
sv/rsi_sqrt_cell.sv
sv/rsi_sqrt_chain.sv
sv/rsi_div_cell.sv
sv/ray_sphere_intersect.sv
tb/sv/ray_sphere_intersect_test.sv
